>>> hdl/fdm_pkg.sv
// Shared types and codes for the frame descriptor mailbox.
// Holds the request and response beat structs, command, verdict, event,
// stat and register codes. No dependencies.
package fdm_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;
   localparam int NumEvents     = 12;
   localparam int StatIdxWidth  = 5;

   localparam logic [2:0] CMD_PUBLISH   = 3'd0;
   localparam logic [2:0] CMD_TAKE      = 3'd1;
   localparam logic [2:0] CMD_CHECK     = 3'd2;
   localparam logic [2:0] CMD_COMMIT    = 3'd3;
   localparam logic [2:0] CMD_PRESENTED = 3'd4;
   localparam logic [2:0] CMD_REPEAT    = 3'd5;
   localparam logic [2:0] CMD_READ_STAT = 3'd6;

   localparam logic [2:0] VERDICT_ACCEPT      = 3'd0;
   localparam logic [2:0] VERDICT_QUARANTINED = 3'd1;
   localparam logic [2:0] VERDICT_ANOMALY     = 3'd2;
   localparam logic [2:0] VERDICT_INCOMPLETE  = 3'd3;
   localparam logic [2:0] VERDICT_NO_SLOT     = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CSR_RING_SLOTS      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_EXPECTED_BLOCKS = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAJORITY_MASK   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ANOMALY_MASK    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_COMPLETE_MASK   = 3'd4;

   localparam logic [15:0] RESET_RING_SLOTS      = 16'd0;
   localparam logic [15:0] RESET_EXPECTED_BLOCKS = 16'd360;
   localparam logic [31:0] RESET_MAJORITY_MASK   = 32'd4;
   localparam logic [31:0] RESET_ANOMALY_MASK    = 32'd3;
   localparam logic [31:0] RESET_COMPLETE_MASK   = 32'd8;

   localparam int EV_CLOSED     = 0;
   localparam int EV_QUAR       = 1;
   localparam int EV_ANOM       = 2;
   localparam int EV_INCOMPLETE = 3;
   localparam int EV_COMPLETE   = 4;
   localparam int EV_DROPPED    = 5;
   localparam int EV_PUBLISHED  = 6;
   localparam int EV_TAKEN      = 7;
   localparam int EV_CONVERTED  = 8;
   localparam int EV_OVERRUN    = 9;
   localparam int EV_PRESENTED  = 10;
   localparam int EV_REPEATED   = 11;

   localparam logic [StatIdxWidth-1:0] STAT_INTERVAL_MIN     = 5'd12;
   localparam logic [StatIdxWidth-1:0] STAT_INTERVAL_MAX     = 5'd13;
   localparam logic [StatIdxWidth-1:0] STAT_INTERVAL_TOTAL   = 5'd14;
   localparam logic [StatIdxWidth-1:0] STAT_INTERVAL_SAMPLES = 5'd15;
   localparam logic [StatIdxWidth-1:0] STAT_CONVERT_MIN      = 5'd16;
   localparam logic [StatIdxWidth-1:0] STAT_CONVERT_MAX      = 5'd17;
   localparam logic [StatIdxWidth-1:0] STAT_CONVERT_TOTAL    = 5'd18;
   localparam logic [StatIdxWidth-1:0] STAT_CONVERT_SAMPLES  = 5'd19;
   localparam logic [StatIdxWidth-1:0] STAT_PUBLISH_SEQUENCE = 5'd20;

   localparam logic [31:0] MIN_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]              cmd;
      logic [31:0]             frame_number;
      logic [15:0]             block_count;
      logic [31:0]             frame_flags;
      logic                    slot_present;
      logic [15:0]             slot_number;
      logic [63:0]             first_time;
      logic [63:0]             last_time;
      logic [31:0]             held_sequence;
      logic                    result_intact;
      logic [31:0]             conversion_time;
      logic [StatIdxWidth-1:0] stat_index;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        ok;
      logic [31:0] desc_frame_number;
      logic [31:0] desc_sequence;
      logic [63:0] desc_first_time;
      logic [63:0] desc_last_time;
      logic [15:0] desc_slot;
      logic [15:0] desc_blocks;
      logic [31:0] desc_flags;
      logic [63:0] stat_value;
   } rsp_beat_type;

   typedef struct packed {
      logic [NumEvents-1:0] bump;
      logic                 interval_en;
      logic [31:0]          interval_delta;
      logic                 convert_en;
      logic [31:0]          convert_value;
   } stat_update_type;

endpackage

>>> hdl/fdm_stat_bank.sv
// Event counters and interval / conversion aggregates of the mailbox.
// Depends on fdm_pkg for the update struct and stat codes.
module fdm_stat_bank (
   input  logic                             clock,
   input  logic                             reset,
   input  fdm_pkg::stat_update_type         update,
   input  logic [31:0]                      publish_sequence,
   input  logic [fdm_pkg::StatIdxWidth-1:0] stat_index,
   output logic [63:0]                      stat_value
);
   import fdm_pkg::*;

   logic [31:0] counter_ff [NumEvents];
   logic [31:0] interval_min_ff;
   logic [31:0] interval_max_ff;
   logic [63:0] interval_total_ff;
   logic [31:0] interval_samples_ff;
   logic [31:0] convert_min_ff;
   logic [31:0] convert_max_ff;
   logic [63:0] convert_total_ff;
   logic [31:0] convert_samples_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumEvents; i++) begin
            counter_ff[i] <= '0;
         end
         interval_min_ff     <= MIN_RESET;
         interval_max_ff     <= '0;
         interval_total_ff   <= '0;
         interval_samples_ff <= '0;
         convert_min_ff      <= MIN_RESET;
         convert_max_ff      <= '0;
         convert_total_ff    <= '0;
         convert_samples_ff  <= '0;
      end else begin
         for (int i = 0; i < NumEvents; i++) begin
            if (update.bump[i]) begin
               counter_ff[i] <= counter_ff[i] + 32'd1;
            end
         end
         if (update.interval_en) begin
            if (update.interval_delta < interval_min_ff) begin
               interval_min_ff <= update.interval_delta;
            end
            if (update.interval_delta > interval_max_ff) begin
               interval_max_ff <= update.interval_delta;
            end
            interval_total_ff   <= interval_total_ff + {32'd0, update.interval_delta};
            interval_samples_ff <= interval_samples_ff + 32'd1;
         end
         if (update.convert_en) begin
            if (update.convert_value < convert_min_ff) begin
               convert_min_ff <= update.convert_value;
            end
            if (update.convert_value > convert_max_ff) begin
               convert_max_ff <= update.convert_value;
            end
            convert_total_ff   <= convert_total_ff + {32'd0, update.convert_value};
            convert_samples_ff <= convert_samples_ff + 32'd1;
         end
      end
   end

   always_comb begin
      stat_value = '0;
      if (stat_index < StatIdxWidth'(NumEvents)) begin
         stat_value = {32'd0, counter_ff[stat_index[3:0]]};
      end else begin
         unique case (stat_index)
            STAT_INTERVAL_MIN:     stat_value = {32'd0, interval_min_ff};
            STAT_INTERVAL_MAX:     stat_value = {32'd0, interval_max_ff};
            STAT_INTERVAL_TOTAL:   stat_value = interval_total_ff;
            STAT_INTERVAL_SAMPLES: stat_value = {32'd0, interval_samples_ff};
            STAT_CONVERT_MIN:      stat_value = {32'd0, convert_min_ff};
            STAT_CONVERT_MAX:      stat_value = {32'd0, convert_max_ff};
            STAT_CONVERT_TOTAL:    stat_value = convert_total_ff;
            STAT_CONVERT_SAMPLES:  stat_value = {32'd0, convert_samples_ff};
            STAT_PUBLISH_SEQUENCE: stat_value = {32'd0, publish_sequence};
            default:               stat_value = '0;
         endcase
      end
   end

endmodule

>>> hdl/frame_descriptor_mailbox_unit.sv
// Top level of the frame descriptor mailbox: config registers, pending
// descriptor, publish classification and the response register.
// Depends on fdm_pkg and fdm_stat_bank.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start and not busy
//   response  rsp_valid, rsp_data            one-cycle strobe, never held off
//   config    csr_we, csr_index, csr_wdata   written when csr_we
//
// One command per cycle; busy stays low. The response appears in the cycle
// after the command is taken, set by the single response register.
// Reset is synchronous; it loads the config reset values and clears the pending flag and counters.
// The receiver cannot stall, so no response is ever held.
module frame_descriptor_mailbox_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  fdm_pkg::req_beat_type             req_data,
   output logic                              rsp_valid,
   output fdm_pkg::rsp_beat_type             rsp_data,
   input  logic                              csr_we,
   input  logic [fdm_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [fdm_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import fdm_pkg::*;

   logic [15:0] ring_slots_ff;
   logic [15:0] expected_blocks_ff;
   logic [31:0] majority_mask_ff;
   logic [31:0] anomaly_mask_ff;
   logic [31:0] complete_mask_ff;

   logic        pending_valid_ff, pending_valid_in;
   logic [31:0] pending_frame_ff;
   logic [31:0] pending_sequence_ff;
   logic [63:0] pending_first_ff;
   logic [63:0] pending_last_ff;
   logic [15:0] pending_slot_ff;
   logic [15:0] pending_blocks_ff;
   logic [31:0] pending_flags_ff;
   logic [31:0] publish_sequence_ff, publish_sequence_in;
   logic [63:0] last_publish_ff;
   logic        seen_publish_ff;

   logic         rsp_valid_ff;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic [2:0]      verdict;
   logic            publish_ok;
   logic            take_ok;
   logic [63:0]     gap;
   logic [31:0]     distance;
   logic [63:0]     stat_value;
   stat_update_type update;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_slots_ff      <= RESET_RING_SLOTS;
         expected_blocks_ff <= RESET_EXPECTED_BLOCKS;
         majority_mask_ff   <= RESET_MAJORITY_MASK;
         anomaly_mask_ff    <= RESET_ANOMALY_MASK;
         complete_mask_ff   <= RESET_COMPLETE_MASK;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RING_SLOTS:      ring_slots_ff      <= csr_wdata[15:0];
            CSR_EXPECTED_BLOCKS: expected_blocks_ff <= csr_wdata[15:0];
            CSR_MAJORITY_MASK:   majority_mask_ff   <= csr_wdata;
            CSR_ANOMALY_MASK:    anomaly_mask_ff    <= csr_wdata;
            CSR_COMPLETE_MASK:   complete_mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (|(req_data.frame_flags & majority_mask_ff)) begin
         verdict = VERDICT_QUARANTINED;
      end else if (|(req_data.frame_flags & anomaly_mask_ff)) begin
         verdict = VERDICT_ANOMALY;
      end else if (!(|(req_data.frame_flags & complete_mask_ff)) ||
                   req_data.block_count != expected_blocks_ff) begin
         verdict = VERDICT_INCOMPLETE;
      end else if (!req_data.slot_present) begin
         verdict = VERDICT_NO_SLOT;
      end else begin
         verdict = VERDICT_ACCEPT;
      end
   end

   assign gap      = req_data.first_time - last_publish_ff;
   assign distance = publish_sequence_ff - req_data.held_sequence;

   always_comb begin
      publish_ok          = 1'b0;
      take_ok             = 1'b0;
      pending_valid_in    = pending_valid_ff;
      publish_sequence_in = publish_sequence_ff;
      update              = '0;
      rsp_data_in         = '0;
      if (accept) begin
         case (req_data.cmd)
            CMD_PUBLISH: begin
               rsp_data_in.verdict    = verdict;
               update.bump[EV_CLOSED] = 1'b1;
               case (verdict)
                  VERDICT_QUARANTINED: update.bump[EV_QUAR] = 1'b1;
                  VERDICT_ANOMALY:     update.bump[EV_ANOM] = 1'b1;
                  VERDICT_ACCEPT: begin
                     publish_ok                = 1'b1;
                     update.bump[EV_COMPLETE]  = 1'b1;
                     update.bump[EV_PUBLISHED] = 1'b1;
                     update.bump[EV_DROPPED]   = pending_valid_ff;
                     pending_valid_in          = 1'b1;
                     publish_sequence_in       = publish_sequence_ff + 32'd1;
                     update.interval_en        = seen_publish_ff &&
                                                 (req_data.first_time > last_publish_ff);
                     update.interval_delta     = (|gap[63:32]) ? MIN_RESET : gap[31:0];
                  end
                  default:             update.bump[EV_INCOMPLETE] = 1'b1;
               endcase
            end
            CMD_TAKE: begin
               if (pending_valid_ff) begin
                  take_ok                       = 1'b1;
                  pending_valid_in              = 1'b0;
                  update.bump[EV_TAKEN]         = 1'b1;
                  rsp_data_in.ok                = 1'b1;
                  rsp_data_in.desc_frame_number = pending_frame_ff;
                  rsp_data_in.desc_sequence     = pending_sequence_ff;
                  rsp_data_in.desc_first_time   = pending_first_ff;
                  rsp_data_in.desc_last_time    = pending_last_ff;
                  rsp_data_in.desc_slot         = pending_slot_ff;
                  rsp_data_in.desc_blocks       = pending_blocks_ff;
                  rsp_data_in.desc_flags        = pending_flags_ff;
               end
            end
            CMD_CHECK: begin
               rsp_data_in.ok = (ring_slots_ff != 16'd0) &&
                                (distance < {16'd0, ring_slots_ff});
            end
            CMD_COMMIT: begin
               update.bump[EV_CONVERTED] = 1'b1;
               update.bump[EV_OVERRUN]   = !req_data.result_intact;
               update.convert_en         = req_data.conversion_time != 32'd0;
               update.convert_value      = req_data.conversion_time;
               rsp_data_in.ok            = req_data.result_intact;
            end
            CMD_PRESENTED: update.bump[EV_PRESENTED] = 1'b1;
            CMD_REPEAT:    update.bump[EV_REPEATED]  = 1'b1;
            CMD_READ_STAT: rsp_data_in.stat_value    = stat_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff    <= 1'b0;
         publish_sequence_ff <= '0;
         last_publish_ff     <= '0;
         seen_publish_ff     <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         pending_valid_ff    <= pending_valid_in;
         publish_sequence_ff <= publish_sequence_in;
         rsp_valid_ff        <= accept;
         if (publish_ok) begin
            last_publish_ff <= req_data.first_time;
            seen_publish_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (publish_ok) begin
         pending_frame_ff    <= req_data.frame_number;
         pending_sequence_ff <= publish_sequence_in;
         pending_first_ff    <= req_data.first_time;
         pending_last_ff     <= req_data.last_time;
         pending_slot_ff     <= req_data.slot_number;
         pending_blocks_ff   <= req_data.block_count;
         pending_flags_ff    <= req_data.frame_flags;
      end
   end

   fdm_stat_bank u_stat_bank (
      .clock            (clock),
      .reset            (reset),
      .update           (update),
      .publish_sequence (publish_sequence_ff),
      .stat_index       (req_data.stat_index),
      .stat_value       (stat_value)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> dv/tb_frame_descriptor_mailbox_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_descriptor_mailbox_unit: a directed table, then random
// command beats under six register settings, each response checked against a table reply
// or a local model. Depends on fdm_pkg and the mailbox RTL only.
module tb_frame_descriptor_mailbox_unit;
   import fdm_pkg::*;

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam int         CYCLE_LIMIT = 200000;

   typedef struct {
      req_beat_type beat;
      bit           known;
      rsp_beat_type reply;
   } directed_row_type;

   typedef struct packed {
      logic [15:0] ring_slots;
      logic [15:0] expected_blocks;
      logic [31:0] majority_mask;
      logic [31:0] anomaly_mask;
      logic [31:0] complete_mask;
      int          idle_pct;
      int          beats;
   } setting_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   req_beat_type             req_data = '0;
   logic                     rsp_valid;
   rsp_beat_type             rsp_data;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   bit                       req_known = 1'b0;
   rsp_beat_type             req_known_reply = '0;

   logic [15:0]              cfg_ring_slots;
   logic [15:0]              cfg_blocks;
   logic [31:0]              cfg_majority;
   logic [31:0]              cfg_anomaly;
   logic [31:0]              cfg_complete;

   bit                       desc_held;
   rsp_beat_type             desc_store;
   logic [31:0]              seq_counter;
   logic [63:0]              last_stamp;
   bit                       stamp_seen;
   logic [31:0]              event_count [NumEvents];
   logic [31:0]              gap_min;
   logic [31:0]              gap_max;
   logic [63:0]              gap_total;
   logic [31:0]              gap_samples;
   logic [31:0]              convert_min;
   logic [31:0]              convert_max;
   logic [63:0]              convert_total;
   logic [31:0]              convert_samples;

   logic [63:0]              stamp_gen;
   rsp_beat_type             awaited_replies [$];
   rsp_beat_type             predicted;
   rsp_beat_type             observed;
   int                       fail_count = 0;
   int                       cycle_count = 0;

   directed_row_type         directed_rows [$];
   setting_type              phase_plan [6];

   frame_descriptor_mailbox_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void clear_mailbox();
      cfg_ring_slots  = RESET_RING_SLOTS;
      cfg_blocks      = RESET_EXPECTED_BLOCKS;
      cfg_majority    = RESET_MAJORITY_MASK;
      cfg_anomaly     = RESET_ANOMALY_MASK;
      cfg_complete    = RESET_COMPLETE_MASK;
      desc_held       = 1'b0;
      desc_store      = '0;
      seq_counter     = '0;
      last_stamp      = '0;
      stamp_seen      = 1'b0;
      for (int i = 0; i < NumEvents; i++) event_count[i] = '0;
      gap_min         = MIN_RESET;
      gap_max         = '0;
      gap_total       = '0;
      gap_samples     = '0;
      convert_min     = MIN_RESET;
      convert_max     = '0;
      convert_total   = '0;
      convert_samples = '0;
   endfunction

   function automatic void write_mailbox_register(logic [CsrIndexWidth-1:0] idx,
                                                  logic [CsrDataWidth-1:0] value);
      case (idx)
         CSR_RING_SLOTS: cfg_ring_slots = value[15:0];
         CSR_EXPECTED_BLOCKS: cfg_blocks = value[15:0];
         CSR_MAJORITY_MASK: cfg_majority = value;
         CSR_ANOMALY_MASK: cfg_anomaly = value;
         CSR_COMPLETE_MASK: cfg_complete = value;
         default: ;
      endcase
   endfunction

   function automatic rsp_beat_type step_mailbox(req_beat_type b);
      rsp_beat_type r;
      logic [2:0]   verdict;
      logic [63:0]  gap;
      logic [31:0]  gap32;
      logic [31:0]  seq_gap;
      r = '0;
      case (b.cmd)
         CMD_PUBLISH: begin
            event_count[EV_CLOSED] += 1;
            if ((b.frame_flags & cfg_majority) != 0) verdict = VERDICT_QUARANTINED;
            else if ((b.frame_flags & cfg_anomaly) != 0) verdict = VERDICT_ANOMALY;
            else if ((b.frame_flags & cfg_complete) == 0 || b.block_count != cfg_blocks)
               verdict = VERDICT_INCOMPLETE;
            else if (!b.slot_present) verdict = VERDICT_NO_SLOT;
            else verdict = VERDICT_ACCEPT;
            r.verdict = verdict;
            case (verdict) inside
               VERDICT_QUARANTINED: event_count[EV_QUAR] += 1;
               VERDICT_ANOMALY: event_count[EV_ANOM] += 1;
               VERDICT_INCOMPLETE, VERDICT_NO_SLOT: event_count[EV_INCOMPLETE] += 1;
               default: begin
                  event_count[EV_COMPLETE] += 1;
                  if (desc_held) event_count[EV_DROPPED] += 1;
                  seq_counter += 1;
                  desc_store                   = '0;
                  desc_store.ok                = 1'b1;
                  desc_store.desc_frame_number = b.frame_number;
                  desc_store.desc_sequence     = seq_counter;
                  desc_store.desc_first_time   = b.first_time;
                  desc_store.desc_last_time    = b.last_time;
                  desc_store.desc_slot         = b.slot_number;
                  desc_store.desc_blocks       = b.block_count;
                  desc_store.desc_flags        = b.frame_flags;
                  desc_held                    = 1'b1;
                  event_count[EV_PUBLISHED] += 1;
                  if (stamp_seen && b.first_time > last_stamp) begin
                     gap   = b.first_time - last_stamp;
                     gap32 = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
                     if (gap32 < gap_min) gap_min = gap32;
                     if (gap32 > gap_max) gap_max = gap32;
                     gap_total   += 64'(gap32);
                     gap_samples += 1;
                  end
                  last_stamp = b.first_time;
                  stamp_seen = 1'b1;
               end
            endcase
         end
         CMD_TAKE: begin
            if (desc_held) begin
               r         = desc_store;
               desc_held = 1'b0;
               event_count[EV_TAKEN] += 1;
            end
         end
         CMD_CHECK: begin
            if (cfg_ring_slots != 0) begin
               seq_gap = seq_counter - b.held_sequence;
               r.ok    = seq_gap < 32'(cfg_ring_slots);
            end
         end
         CMD_COMMIT: begin
            event_count[EV_CONVERTED] += 1;
            if (b.conversion_time != 0) begin
               if (b.conversion_time < convert_min) convert_min = b.conversion_time;
               if (b.conversion_time > convert_max) convert_max = b.conversion_time;
               convert_total   += 64'(b.conversion_time);
               convert_samples += 1;
            end
            if (!b.result_intact) event_count[EV_OVERRUN] += 1;
            else r.ok = 1'b1;
         end
         CMD_PRESENTED: event_count[EV_PRESENTED] += 1;
         CMD_REPEAT: event_count[EV_REPEATED] += 1;
         CMD_READ_STAT: begin
            if (b.stat_index < NumEvents) r.stat_value = 64'(event_count[b.stat_index[3:0]]);
            else begin
               case (b.stat_index)
                  STAT_INTERVAL_MIN: r.stat_value = 64'(gap_min);
                  STAT_INTERVAL_MAX: r.stat_value = 64'(gap_max);
                  STAT_INTERVAL_TOTAL: r.stat_value = gap_total;
                  STAT_INTERVAL_SAMPLES: r.stat_value = 64'(gap_samples);
                  STAT_CONVERT_MIN: r.stat_value = 64'(convert_min);
                  STAT_CONVERT_MAX: r.stat_value = 64'(convert_max);
                  STAT_CONVERT_TOTAL: r.stat_value = convert_total;
                  STAT_CONVERT_SAMPLES: r.stat_value = 64'(convert_samples);
                  STAT_PUBLISH_SEQUENCE: r.stat_value = 64'(seq_counter);
                  default: r.stat_value = '0;
               endcase
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               $error("response beat with nothing outstanding");
               fail_count++;
            end else begin
               predicted = awaited_replies.pop_front();
               observed  = rsp_data;
               check_field("verdict", predicted.verdict, observed.verdict);
               check_field("ok", predicted.ok, observed.ok);
               check_field("desc_frame_number", predicted.desc_frame_number,
                           observed.desc_frame_number);
               check_field("desc_sequence", predicted.desc_sequence, observed.desc_sequence);
               check_field("desc_first_time", predicted.desc_first_time,
                           observed.desc_first_time);
               check_field("desc_last_time", predicted.desc_last_time,
                           observed.desc_last_time);
               check_field("desc_slot", predicted.desc_slot, observed.desc_slot);
               check_field("desc_blocks", predicted.desc_blocks, observed.desc_blocks);
               check_field("desc_flags", predicted.desc_flags, observed.desc_flags);
               check_field("stat_value", predicted.stat_value, observed.stat_value);
            end
         end
         if (csr_we) write_mailbox_register(csr_index, csr_wdata);
         if (start && !busy) begin
            predicted = step_mailbox(req_data);
            awaited_replies.push_back(req_known ? req_known_reply : predicted);
         end
      end
   end

   function automatic req_beat_type any_beat(logic [2:0] cmd);
      req_beat_type b;
      b.cmd             = cmd;
      b.frame_number    = $urandom;
      b.block_count     = 16'($urandom);
      b.frame_flags     = $urandom;
      b.slot_present    = 1'($urandom);
      b.slot_number     = 16'($urandom);
      b.first_time      = {$urandom, $urandom};
      b.last_time       = {$urandom, $urandom};
      b.held_sequence   = $urandom;
      b.result_intact   = 1'($urandom);
      b.conversion_time = $urandom;
      b.stat_index      = StatIdxWidth'($urandom);
      return b;
   endfunction

   function automatic logic [63:0] next_stamp();
      case ($urandom_range(19))
         0: stamp_gen = {$urandom, $urandom};
         1: stamp_gen = stamp_gen + {32'($urandom_range(1, 7)), 32'($urandom)};
         2: ;
         3: stamp_gen = stamp_gen - 64'($urandom_range(1, 1000));
         default: stamp_gen = stamp_gen + 64'($urandom_range(1, 100000));
      endcase
      return stamp_gen;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int unsigned  pick;
      int unsigned  shape;
      logic [31:0]  blocked;
      logic [31:0]  allowed;
      pick = $urandom_range(99);
      if (pick < 35) begin
         b       = any_beat(CMD_PUBLISH);
         shape   = $urandom_range(9);
         blocked = cfg_majority | cfg_anomaly;
         allowed = cfg_complete & ~blocked;
         if (shape < 7) begin
            b.frame_flags  = (b.frame_flags & ~blocked) | (allowed & -allowed);
            b.block_count  = cfg_blocks;
            b.slot_present = (shape != 6);
         end else if (shape == 7) begin
            b.block_count = cfg_blocks;
         end
         b.first_time = next_stamp();
      end else if (pick < 55) begin
         b = any_beat(CMD_TAKE);
      end else if (pick < 70) begin
         b = any_beat(CMD_CHECK);
         if ($urandom_range(4) != 0)
            b.held_sequence = seq_counter - $urandom_range(0, cfg_ring_slots + 2);
      end else if (pick < 80) begin
         b = any_beat(CMD_COMMIT);
         case ($urandom_range(3))
            0: b.conversion_time = '0;
            1: b.conversion_time = $urandom_range(1, 5000);
            default: ;
         endcase
      end else if (pick < 85) begin
         b = any_beat(CMD_PRESENTED);
      end else if (pick < 90) begin
         b = any_beat(CMD_REPEAT);
      end else if (pick < 99) begin
         b = any_beat(CMD_READ_STAT);
      end else begin
         b = any_beat(CMD_UNUSED);
      end
      return b;
   endfunction

   function automatic rsp_beat_type plain_reply(logic [2:0] verdict, logic ok,
                                                logic [63:0] stat);
      rsp_beat_type r;
      r            = '0;
      r.verdict    = verdict;
      r.ok         = ok;
      r.stat_value = stat;
      return r;
   endfunction

   task automatic add_row(req_beat_type beat, bit known, rsp_beat_type reply);
      directed_row_type row;
      row.beat  = beat;
      row.known = known;
      row.reply = reply;
      directed_rows.push_back(row);
   endtask

   // hold start high across back-to-back beats; drop it only for a gap
   task automatic send_beat(req_beat_type beat, bit known, rsp_beat_type reply,
                            int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_data        <= beat;
      req_known       <= known;
      req_known_reply <= reply;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(setting_type s);
      logic [CsrIndexWidth-1:0] idx [5];
      logic [CsrDataWidth-1:0]  value [5];
      logic [15:0]              junk_a;
      logic [15:0]              junk_b;
      junk_a   = 16'($urandom);
      junk_b   = 16'($urandom);
      idx[0]   = CSR_RING_SLOTS;
      idx[1]   = CSR_EXPECTED_BLOCKS;
      idx[2]   = CSR_MAJORITY_MASK;
      idx[3]   = CSR_ANOMALY_MASK;
      idx[4]   = CSR_COMPLETE_MASK;
      value[0] = {junk_a, s.ring_slots};
      value[1] = {junk_b, s.expected_blocks};
      value[2] = s.majority_mask;
      value[3] = s.anomaly_mask;
      value[4] = s.complete_mask;
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      req_beat_type b;
      clear_mailbox();
      stamp_gen = {$urandom, $urandom};

      b = any_beat(CMD_READ_STAT);
      b.stat_index = STAT_PUBLISH_SEQUENCE;
      add_row(b, 1'b1, plain_reply('0, 1'b0, '0));
      b.stat_index = STAT_INTERVAL_MIN;
      add_row(b, 1'b1, plain_reply('0, 1'b0, MIN_RESET));
      b.stat_index = STAT_CONVERT_MIN;
      add_row(b, 1'b1, plain_reply('0, 1'b0, MIN_RESET));
      add_row(any_beat(CMD_TAKE), 1'b1, '0);
      add_row(any_beat(CMD_CHECK), 1'b1, '0);

      b = any_beat(CMD_PUBLISH);
      b.frame_flags = 32'h4;
      add_row(b, 1'b1, plain_reply(VERDICT_QUARANTINED, 1'b0, '0));
      b.frame_flags = 32'h1;
      add_row(b, 1'b1, plain_reply(VERDICT_ANOMALY, 1'b0, '0));
      b.frame_flags = 32'h8;
      b.block_count = 16'd359;
      add_row(b, 1'b1, plain_reply(VERDICT_INCOMPLETE, 1'b0, '0));
      b.frame_flags  = 32'h0;
      b.block_count  = 16'd360;
      b.slot_present = 1'b1;
      add_row(b, 1'b1, plain_reply(VERDICT_INCOMPLETE, 1'b0, '0));
      b.frame_flags  = 32'h8;
      b.slot_present = 1'b0;
      add_row(b, 1'b1, plain_reply(VERDICT_NO_SLOT, 1'b0, '0));

      b.frame_flags  = 32'hFFFF_FFF8;
      b.slot_present = 1'b1;
      b.slot_number  = '1;
      b.frame_number = '1;
      b.first_time   = '0;
      b.last_time    = '1;
      add_row(b, 1'b1, plain_reply(VERDICT_ACCEPT, 1'b0, '0));
      b.frame_flags  = 32'h8;
      b.slot_number  = '0;
      b.frame_number = '0;
      b.first_time   = '1;
      b.last_time    = '0;
      add_row(b, 1'b0, '0);
      b.first_time = 64'd5;
      add_row(b, 1'b0, '0);
      add_row(b, 1'b0, '0);
      add_row(any_beat(CMD_TAKE), 1'b0, '0);
      add_row(any_beat(CMD_TAKE), 1'b1, '0);

      b = any_beat(CMD_COMMIT);
      b.result_intact   = 1'b1;
      b.conversion_time = '0;
      add_row(b, 1'b1, plain_reply('0, 1'b1, '0));
      b.result_intact   = 1'b0;
      b.conversion_time = '1;
      add_row(b, 1'b1, '0);
      b.result_intact   = 1'b1;
      b.conversion_time = 32'd1;
      add_row(b, 1'b0, '0);
      add_row(any_beat(CMD_PRESENTED), 1'b0, '0);
      add_row(any_beat(CMD_REPEAT), 1'b0, '0);
      b = '1;
      b.cmd = CMD_UNUSED;
      add_row(b, 1'b1, '0);
      b = any_beat(CMD_READ_STAT);
      b.stat_index = '1;
      add_row(b, 1'b1, '0);
      b.stat_index = StatIdxWidth'(EV_DROPPED);
      add_row(b, 1'b0, '0);
      b.stat_index = STAT_INTERVAL_TOTAL;
      add_row(b, 1'b0, '0);

      phase_plan[0] = '{16'd4, 16'd360, 32'h4, 32'h3, 32'h8, 27, 320};
      phase_plan[1] = '{16'hFFFF, 16'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 27, 320};
      phase_plan[2] = '{16'd1, 16'hFFFF, 32'h8000_0000, 32'h0001_0000, 32'h1, 52, 320};
      phase_plan[3] = '{16'd0, 16'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 52, 320};
      phase_plan[4] = '{16'd16, 16'd360, 32'h0000_F000, 32'h0000_0F00, 32'h0000_00F0,
                        0, 320};
      phase_plan[5] = '{16'd3, 16'd1, 32'h4, 32'h3, 32'h8, 0, 320};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].reply, 27);

      foreach (phase_plan[p]) begin
         settle();
         load_settings(phase_plan[p]);
         repeat (phase_plan[p].beats) send_beat(random_beat(), 1'b0, '0, phase_plan[p].idle_pct);
      end
      settle();

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
hdl/fdm_pkg.sv
hdl/fdm_stat_bank.sv
hdl/frame_descriptor_mailbox_unit.sv
dv/tb_frame_descriptor_mailbox_unit.sv
